[hw/rtl/svdm_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// svdm_pkg
// Shared constants, types and helpers of the split virtqueue descriptor manager.
// ---------------------------------------------------------------------------
package svdm_pkg;

	localparam int QUEUE_MAX = 256;
	localparam int IDX_W     = $clog2(QUEUE_MAX);
	localparam int CNT_W     = IDX_W + 1;

	localparam logic [2:0] CMD_ADD_SINGLE = 3'd0;
	localparam logic [2:0] CMD_ADD_PAIR   = 3'd1;
	localparam logic [2:0] CMD_TAKE_USED  = 3'd2;
	localparam logic [2:0] CMD_EN_NOTIFY  = 3'd3;
	localparam logic [2:0] CMD_DEV_USED   = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_NO_USED = 2'd2;

	localparam int FLAG_NEXT     = 0;
	localparam int FLAG_WRITE    = 1;
	localparam int FLAG_INDIRECT = 2;

	typedef struct packed {
		logic [63:0]      token;
		logic [63:0]      addr;
		logic [31:0]      len;
		logic [2:0]       flags;
		logic [IDX_W-1:0] next;
	} desc_t;

	typedef struct packed {
		logic [IDX_W-1:0] id;
		logic [31:0]      len;
	} used_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;
		logic exec;
		logic pair2;
		logic tk2;
		logic tk3;
		logic fin;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       lack2;
		logic       empty;
		logic       cont;
		logic       out_free;
	} sts_t;

	// clamp, round down to a power of two, floor of two
	function automatic logic [CNT_W-1:0] eff_size(input logic [8:0] v);
		logic [CNT_W-1:0] c;
		logic [CNT_W-1:0] r;
		c = (v > 9'(QUEUE_MAX)) ? CNT_W'(QUEUE_MAX) : CNT_W'(v);
		r = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (c[i]) r = CNT_W'(1) << i;
		end
		if (r < CNT_W'(2)) r = CNT_W'(2);
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/svdm_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// svdm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module svdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/svdm_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// svdm_ctrl
// Command sequencer: walks each request through its table access steps.
// ---------------------------------------------------------------------------
module svdm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire svdm_pkg::sts_t sts,
	output svdm_pkg::ctl_t     ctl
);
	import svdm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_PAIR2 = 3'd2;
	localparam logic [2:0] S_TK2   = 3'd3;
	localparam logic [2:0] S_TK3   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				ctl.cap = in_valid;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.cmd == CMD_ADD_PAIR && !sts.lack2) state_d = S_PAIR2;
				else if (sts.cmd == CMD_TAKE_USED && !sts.empty) state_d = S_TK2;
				else state_d = S_FIN;
			end
			S_PAIR2: begin
				ctl.pair2 = 1'b1;
				state_d   = S_FIN;
			end
			S_TK2: begin
				ctl.tk2 = 1'b1;
				state_d = sts.cont ? S_TK3 : S_FIN;
			end
			S_TK3: begin
				ctl.tk3 = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register can take the result
				ctl.fin = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

[hw/rtl/svdm_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// svdm_datapath
// Descriptor table, rings, free list and the result register.
// ---------------------------------------------------------------------------
module svdm_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire svdm_pkg::ctl_t ctl,
	output svdm_pkg::sts_t      sts,
	input  wire logic [239:0]   in_data,
	input  wire logic [2:0]     in_user,
	input  wire logic           cfg_valid,
	input  wire logic [8:0]     cfg_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [135:0]        out_payload,
	output logic [1:0]          out_user
);
	import svdm_pkg::*;

	logic [CNT_W-1:0] size_q, head_q, total_q;
	logic [15:0]      avail_q, dev_q, drv_q;
	logic             notify_q;
	logic [IDX_W-1:0] mask;

	logic [2:0]  cmd_q;
	logic [63:0] fa_q, sa_q;
	logic [31:0] fl_q, sl_q, ul_q;
	logic        dw_q;
	logic [7:0]  uid_q;

	logic [1:0]       r_status_q;
	logic [IDX_W-1:0] r_head_q;
	logic [63:0]      r_token_q;
	logic [31:0]      r_len_q;
	logic             r_pend_q;

	logic [IDX_W-1:0] pair_i_q, nx_q;

	// free-list links: entries not yet written read as index plus one
	logic [QUEUE_MAX-1:0] link_vld_q;
	logic                 link_vld_s1;
	logic [IDX_W-1:0]     link_addr_s1;
	logic [IDX_W-1:0]     link_raddr, link_waddr;
	logic [CNT_W-1:0]     link_rdata, link_wdata, link_eff;
	logic                 link_we;
	logic [IDX_W-1:0]     pair_i;

	desc_t            desc_wdata, desc_rdata;
	logic [IDX_W-1:0] desc_waddr, desc_raddr;
	logic             desc_we;

	used_t used_wdata, used_rdata;
	logic  used_we;
	logic  avail_we;

	logic exec_single, exec_pair, exec_take, out_load, cont;

	assign mask     = IDX_W'(size_q - CNT_W'(1));
	assign link_eff = link_vld_s1 ? link_rdata : (CNT_W'(link_addr_s1) + CNT_W'(1));
	assign pair_i   = link_eff[IDX_W-1:0] & mask;

	assign exec_single = ctl.exec && cmd_q == CMD_ADD_SINGLE && total_q != '0;
	assign exec_pair   = ctl.exec && cmd_q == CMD_ADD_PAIR && total_q >= CNT_W'(2);
	assign exec_take   = ctl.exec && cmd_q == CMD_TAKE_USED && drv_q != dev_q;
	assign cont        = desc_rdata.flags[FLAG_NEXT] && !desc_rdata.flags[FLAG_INDIRECT];
	assign out_load    = ctl.fin;

	assign sts.cmd      = cmd_q;
	assign sts.lack2    = total_q < CNT_W'(2);
	assign sts.empty    = drv_q == dev_q;
	assign sts.cont     = cont;
	assign sts.out_free = !out_valid || out_ready;

	assign link_raddr = ctl.exec ? pair_i : (head_q[IDX_W-1:0] & mask);
	assign link_we    = ctl.tk2 || ctl.tk3;
	assign link_waddr = ctl.tk2 ? r_head_q : nx_q;
	assign link_wdata = head_q;

	always_comb begin
		desc_we    = exec_single || exec_pair || ctl.pair2;
		desc_waddr = ctl.pair2 ? pair_i_q : (head_q[IDX_W-1:0] & mask);
		desc_wdata = '0;
		if (ctl.pair2) begin
			desc_wdata.token = sa_q;
			desc_wdata.addr  = sa_q;
			desc_wdata.len   = sl_q;
			desc_wdata.flags[FLAG_WRITE] = 1'b1;
		end else begin
			desc_wdata.token = fa_q;
			desc_wdata.addr  = fa_q;
			desc_wdata.len   = fl_q;
			if (cmd_q == CMD_ADD_PAIR) begin
				desc_wdata.flags[FLAG_NEXT] = 1'b1;
				desc_wdata.next = pair_i;
			end else begin
				desc_wdata.flags[FLAG_WRITE] = dw_q;
			end
		end
	end
	assign desc_raddr = used_rdata.id & mask;

	assign used_we    = ctl.exec && cmd_q == CMD_DEV_USED;
	assign used_wdata = '{id: uid_q, len: ul_q};
	assign avail_we   = exec_single || exec_pair;

	svdm_ram #(.WIDTH($bits(desc_t)), .DEPTH(QUEUE_MAX)) u_desc (
		.clk(clk), .we(desc_we), .waddr(desc_waddr), .wdata(desc_wdata),
		.raddr(desc_raddr), .rdata(desc_rdata)
	);

	svdm_ram #(.WIDTH(CNT_W), .DEPTH(QUEUE_MAX)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);

	svdm_ram #(.WIDTH($bits(used_t)), .DEPTH(QUEUE_MAX)) u_used (
		.clk(clk), .we(used_we), .waddr(dev_q[IDX_W-1:0] & mask), .wdata(used_wdata),
		.raddr(drv_q[IDX_W-1:0] & mask), .rdata(used_rdata)
	);

	logic [IDX_W-1:0] avail_rdata;
	svdm_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_MAX)) u_avail (
		.clk(clk), .we(avail_we), .waddr(avail_q[IDX_W-1:0] & mask),
		.wdata(head_q[IDX_W-1:0] & mask), .raddr(avail_q[IDX_W-1:0] & mask),
		.rdata(avail_rdata)
	);

	always_ff @(posedge clk) begin
		link_vld_s1  <= link_vld_q[link_raddr];
		link_addr_s1 <= link_raddr;
		if (ctl.cap) begin
			cmd_q <= in_user;
			fa_q  <= in_data[63:0];
			fl_q  <= in_data[95:64];
			dw_q  <= in_data[96];
			sa_q  <= in_data[160:97];
			sl_q  <= in_data[192:161];
			uid_q <= in_data[200:193];
			ul_q  <= in_data[232:201];
		end
		if (exec_pair) pair_i_q <= pair_i;
		if (ctl.tk2) nx_q <= desc_rdata.next & mask;
		if (out_load) begin
			out_user    <= r_status_q;
			out_payload <= {6'd0, r_pend_q, avail_q, total_q, r_len_q, r_token_q, r_head_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= CNT_W'(QUEUE_MAX);
			head_q     <= '0;
			total_q    <= CNT_W'(QUEUE_MAX);
			avail_q    <= '0;
			dev_q      <= '0;
			drv_q      <= '0;
			notify_q   <= 1'b0;
			link_vld_q <= '0;
			out_valid  <= 1'b0;
			r_status_q <= ST_OK;
			r_head_q   <= '0;
			r_token_q  <= '0;
			r_len_q    <= '0;
			r_pend_q   <= 1'b0;
		end else if (cfg_valid) begin
			// rebuild the queue at the new size
			size_q     <= eff_size(cfg_data);
			total_q    <= eff_size(cfg_data);
			head_q     <= '0;
			avail_q    <= '0;
			dev_q      <= '0;
			drv_q      <= '0;
			notify_q   <= 1'b0;
			link_vld_q <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (ctl.cap) begin
				r_status_q <= ST_OK;
				r_head_q   <= '0;
				r_token_q  <= '0;
				r_len_q    <= '0;
				r_pend_q   <= 1'b0;
			end
			if (ctl.exec) begin
				case (cmd_q)
					CMD_ADD_SINGLE, CMD_ADD_PAIR: begin
						if (avail_we) begin
							r_head_q <= head_q[IDX_W-1:0] & mask;
							avail_q  <= avail_q + 16'd1;
						end else begin
							r_status_q <= ST_NO_FREE;
						end
						if (exec_single) begin
							head_q  <= link_eff;
							total_q <= total_q - CNT_W'(1);
						end
					end
					CMD_TAKE_USED: begin
						if (exec_take) begin
							r_head_q <= used_rdata.id & mask;
							r_len_q  <= used_rdata.len;
							drv_q    <= drv_q + 16'd1;
						end else begin
							r_status_q <= ST_NO_USED;
						end
					end
					CMD_EN_NOTIFY: begin
						notify_q <= 1'b0;
						r_pend_q <= dev_q != drv_q;
					end
					CMD_DEV_USED: begin
						dev_q    <= dev_q + 16'd1;
						r_head_q <= uid_q;
					end
					default: ;
				endcase
			end
			if (ctl.pair2) begin
				head_q  <= link_eff;
				total_q <= total_q - CNT_W'(2);
			end
			if (ctl.tk2) r_token_q <= desc_rdata.token;
			if (link_we) begin
				link_vld_q[link_waddr] <= 1'b1;
				head_q <= CNT_W'(link_waddr);
				if (total_q < size_q) total_q <= total_q + CNT_W'(1);
			end
		end
	end

	logic unused_ok;
	assign unused_ok = notify_q ^ (^avail_rdata);
endmodule
`default_nettype wire

[hw/rtl/split_virtqueue_descriptor_manager.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// split_virtqueue_descriptor_manager
// Driver side of a split virtqueue with a LIFO free-descriptor list.
// ---------------------------------------------------------------------------
// One request is processed at a time and returns exactly one result. Each
// request is captured, executed, then finished by loading the result register;
// an accepted add pair adds a step that writes its second descriptor, and a
// take adds a step per descriptor that it frees, at most a chained pair. The
// steps follow from the registered reads of the free-link, used-ring and
// descriptor RAMs, which the sequencer chains one after another. A result
// waiting in the output register does not block acceptance of the next
// request. A queue-size write rebuilds the queue at once (free links come
// back through per-entry valid bits), with no clearing pass.
module split_virtqueue_descriptor_manager (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [63:0] first_address, [95:64] first_length, [96] device_writes,
	// [160:97] second_address, [192:161] second_length, [200:193] used_id,
	// [232:201] used_length, rest zero
	input  wire logic [239:0] s_axis_tdata,
	// [2:0] command
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [7:0] head_index, [71:8] token_address, [103:72] returned_length,
	// [112:104] free_count, [128:113] avail_index, [129] used_pending, rest zero
	output logic [135:0]      m_axis_tdata,
	// [1:0] status
	output logic [1:0]        m_axis_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [8:0]   cfg_data
);
	import svdm_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	svdm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .sts(sts), .ctl(ctl)
	);

	svdm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_data(s_axis_tdata), .in_user(s_axis_tuser),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_payload(m_axis_tdata), .out_user(m_axis_tuser)
	);
endmodule
`default_nettype wire

[hw/rtl/svdm_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// svdm_checker
// Port-level checks of the descriptor manager, bound to the top level.
// ---------------------------------------------------------------------------
module svdm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [135:0] m_axis_tdata,
	input wire logic [1:0]   m_axis_tuser
);
	import svdm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[112:104] <= 9'(QUEUE_MAX))
		else $error("free count beyond queue size");

	a_no_used_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_NO_USED |-> m_axis_tdata[103:0] == '0)
		else $error("empty take returned data");

	a_pend_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[129] |-> m_axis_tuser == ST_OK)
		else $error("pending flag with error status");
endmodule

bind split_virtqueue_descriptor_manager svdm_checker u_svdm_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

[test/split_virtqueue_descriptor_manager_test.sv]
// ---------------------------------------------------------------------------
// split_virtqueue_descriptor_manager_test
// Drives add, take, notify and device-used requests at several queue sizes,
// predicts every result from a local model of the free list and rings, and
// checks each response field by field under random source and sink stalls.
// ---------------------------------------------------------------------------
module split_virtqueue_descriptor_manager_test;
	import svdm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] addr1;
		logic [31:0] len1;
		logic        dev_wr;
		logic [63:0] addr2;
		logic [31:0] len2;
		logic [7:0]  uid;
		logic [31:0] ulen;
	} vq_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  head;
		logic [63:0] token;
		logic [31:0] rlen;
		logic [8:0]  free;
		logic [15:0] avail;
		logic        pending;
	} vq_rsp_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [8:0]   cfg_data;

	// model state
	int          qsize;
	logic [63:0] tok_mem[QUEUE_MAX];
	logic [2:0]  flag_mem[QUEUE_MAX];
	logic [7:0]  next_mem[QUEUE_MAX];
	bit          filled[QUEUE_MAX];
	logic [8:0]  link_mem[QUEUE_MAX];
	logic [8:0]  fl_head;
	logic [8:0]  free_total;
	logic [15:0] avail_shadow;
	logic [7:0]  used_id_ring[QUEUE_MAX];
	logic [31:0] used_len_ring[QUEUE_MAX];
	logic [15:0] dev_idx;
	logic [15:0] drv_idx;

	vq_rsp_t     pending_rsp[$];
	logic [7:0]  posted_heads[$];
	int          errors = 0;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          quiet_cycles = 0;

	split_virtqueue_descriptor_manager u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int round_size(input logic [8:0] v);
		int c;
		int r;
		c = (v > 9'd256) ? 256 : int'(v);
		r = 2;
		for (int i = 1; i <= 8; i++) begin
			if (c >= (1 << i)) r = 1 << i;
		end
		return r;
	endfunction

	function automatic void rebuild_queue(input int size);
		qsize = size;
		for (int i = 0; i < QUEUE_MAX; i++) begin
			link_mem[i] = 9'(i + 1);
			filled[i] = 1'b0;
		end
		fl_head = '0;
		free_total = 9'(size);
		avail_shadow = '0;
		dev_idx = '0;
		drv_idx = '0;
		posted_heads.delete();
	endfunction

	function automatic logic [7:0] pop_desc();
		logic [7:0] d;
		d = 8'(fl_head & 9'(qsize - 1));
		fl_head = link_mem[d];
		free_total = free_total - 9'd1;
		filled[d] = 1'b1;
		return d;
	endfunction

	function automatic void push_desc(input logic [7:0] d);
		link_mem[d] = fl_head;
		fl_head = {1'b0, d};
		if (free_total < 9'(qsize)) free_total = free_total + 9'd1;
	endfunction

	function automatic vq_rsp_t predict_queue(input vq_req_t rq);
		vq_rsp_t    r;
		logic [7:0] mask;
		logic [7:0] o;
		logic [7:0] i2;
		logic [7:0] d;
		logic [7:0] nx;
		logic [2:0] f;
		int         slot;
		mask = 8'(qsize - 1);
		r = '{status: ST_OK, head: '0, token: '0, rlen: '0, free: '0, avail: '0,
			pending: 1'b0};
		case (rq.cmd)
			CMD_ADD_SINGLE: begin
				if (free_total < 9'd1) r.status = ST_NO_FREE;
				else begin
					d = pop_desc();
					tok_mem[d] = rq.addr1;
					flag_mem[d] = '0;
					flag_mem[d][FLAG_WRITE] = rq.dev_wr;
					next_mem[d] = '0;
					avail_shadow++;
					posted_heads.push_back(d);
					r.head = d;
				end
			end
			CMD_ADD_PAIR: begin
				if (free_total < 9'd2) r.status = ST_NO_FREE;
				else begin
					o = pop_desc();
					i2 = pop_desc();
					tok_mem[o] = rq.addr1;
					flag_mem[o] = '0;
					flag_mem[o][FLAG_NEXT] = 1'b1;
					next_mem[o] = i2;
					tok_mem[i2] = rq.addr2;
					flag_mem[i2] = '0;
					flag_mem[i2][FLAG_WRITE] = 1'b1;
					next_mem[i2] = '0;
					avail_shadow++;
					posted_heads.push_back(o);
					r.head = o;
				end
			end
			CMD_TAKE_USED: begin
				if (drv_idx == dev_idx) r.status = ST_NO_USED;
				else begin
					slot = int'(drv_idx & 16'(mask));
					d = used_id_ring[slot] & mask;
					r.rlen = used_len_ring[slot];
					drv_idx++;
					r.head = d;
					r.token = tok_mem[d];
					for (int s = 0; s < 2; s++) begin
						f = flag_mem[d];
						nx = next_mem[d] & mask;
						push_desc(d);
						if (f[FLAG_INDIRECT] || !f[FLAG_NEXT]) break;
						d = nx;
					end
				end
			end
			CMD_EN_NOTIFY: r.pending = (dev_idx != drv_idx);
			CMD_DEV_USED: begin
				slot = int'(dev_idx & 16'(mask));
				used_id_ring[slot] = rq.uid;
				used_len_ring[slot] = rq.ulen;
				dev_idx++;
				r.head = rq.uid;
				foreach (posted_heads[k]) begin
					if (posted_heads[k] == (rq.uid & mask)) begin
						posted_heads.delete(k);
						break;
					end
				end
			end
			default: ;
		endcase
		r.free = free_total;
		r.avail = avail_shadow;
		return r;
	endfunction

	function automatic vq_req_t make_req(input logic [2:0] cmd);
		vq_req_t rq;
		rq.cmd = cmd;
		rq.addr1 = {$urandom, $urandom};
		rq.len1 = $urandom;
		rq.dev_wr = 1'($urandom_range(1));
		rq.addr2 = {$urandom, $urandom};
		rq.len2 = $urandom;
		rq.uid = 8'($urandom);
		rq.ulen = $urandom;
		return rq;
	endfunction

	// report a filled descriptor; upper id bits are noise the block must mask
	function automatic vq_req_t make_used(input logic [7:0] d);
		vq_req_t    rq;
		logic [7:0] mask;
		mask = 8'(qsize - 1);
		rq = make_req(CMD_DEV_USED);
		rq.uid = (d & mask) | (8'($urandom) & ~mask);
		return rq;
	endfunction

	task automatic send_request(input vq_req_t rq);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= rq.cmd;
		s_axis_tdata <= {7'd0, rq.ulen, rq.uid, rq.len2, rq.addr2, rq.dev_wr, rq.len1,
			rq.addr1};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_rsp.push_back(predict_queue(rq));
	endtask

	task automatic drain_queue();
		s_axis_tvalid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_qsize(input logic [8:0] v);
		drain_queue();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rebuild_queue(round_size(v));
	endtask

	task automatic send_random(input int count);
		vq_req_t rq;
		int      roll;
		int      d;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 38) begin
				rq = make_req($urandom_range(1) ? CMD_ADD_PAIR : CMD_ADD_SINGLE);
			end else if (roll < 60 && posted_heads.size() != 0) begin
				rq = make_used(posted_heads[$urandom_range(posted_heads.size() - 1)]);
			end else if (roll < 88) begin
				rq = make_req(CMD_TAKE_USED);
			end else if (roll < 93) begin
				rq = make_req(CMD_EN_NOTIFY);
			end else begin
				// stray completion of any filled descriptor, possibly a free one
				d = $urandom_range(qsize - 1);
				if (filled[d]) rq = make_used(8'(d));
				else rq = make_req(CMD_EN_NOTIFY);
			end
			send_request(rq);
		end
	endtask

	task automatic test_empty_and_notify();
		vq_req_t rq;
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_EN_NOTIFY));
		rq = make_req(CMD_ADD_SINGLE);
		send_request(rq);
		send_request(make_used(posted_heads[0]));
		send_request(make_req(CMD_EN_NOTIFY));
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_EN_NOTIFY));
	endtask

	task automatic test_field_extremes();
		vq_req_t rq;
		rq = '{cmd: CMD_ADD_SINGLE, addr1: '1, len1: '1, dev_wr: 1'b1, addr2: '1,
			len2: '1, uid: '1, ulen: '1};
		send_request(rq);
		rq = '{cmd: CMD_ADD_SINGLE, addr1: '0, len1: '0, dev_wr: 1'b0, addr2: '0,
			len2: '0, uid: '0, ulen: '0};
		send_request(rq);
		rq = '{cmd: CMD_ADD_PAIR, addr1: '1, len1: '1, dev_wr: 1'b1, addr2: '1,
			len2: '1, uid: '1, ulen: '1};
		send_request(rq);
		rq = make_used(posted_heads[2]);
		rq.ulen = '1;
		send_request(rq);
		rq = make_used(posted_heads[0]);
		rq.ulen = '0;
		send_request(rq);
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_TAKE_USED));
	endtask

	task automatic test_tiny_queue();
		logic [7:0] h;
		write_qsize(9'd1);
		send_request(make_req(CMD_ADD_PAIR));
		h = posted_heads[0];
		send_request(make_req(CMD_ADD_SINGLE));
		send_request(make_req(CMD_ADD_PAIR));
		// same head reported three times: overrun and over-freeing
		send_request(make_used(h));
		send_request(make_used(h));
		send_request(make_used(h));
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_TAKE_USED));
		send_request(make_req(CMD_ADD_SINGLE));
		send_request(make_req(CMD_ADD_SINGLE));
	endtask

	task automatic test_random_sizes();
		logic [8:0] sizes[8] = '{9'd511, 9'd4, 9'd100, 9'd0, 9'd8, 9'd300, 9'd3, 9'd256};
		int         tx_mix[4] = '{0, 45, 0, 7};
		int         rx_mix[4] = '{0, 0, 45, 7};
		for (int p = 0; p < 8; p++) begin
			write_qsize(sizes[p]);
			tx_idle_pct = tx_mix[p % 4];
			rx_stall_pct = rx_mix[p % 4];
			send_random(140);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		vq_rsp_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", want.status, m_axis_tuser);
				check_field("head_index", want.head, m_axis_tdata[7:0]);
				check_field("token_address", want.token, m_axis_tdata[71:8]);
				check_field("returned_length", want.rlen, m_axis_tdata[103:72]);
				check_field("free_count", want.free, m_axis_tdata[112:104]);
				check_field("avail_index", want.avail, m_axis_tdata[128:113]);
				check_field("used_pending", want.pending, m_axis_tdata[129]);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("split_virtqueue_descriptor_manager test failed");
			$finish;
		end
	end

	initial begin
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rebuild_queue(256);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_notify();
		test_field_extremes();
		test_tiny_queue();
		test_random_sizes();
		drain_queue();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("split_virtqueue_descriptor_manager test passed");
		else $display("split_virtqueue_descriptor_manager test failed");
		$finish;
	end

endmodule
